[src/rwcf_pkg.sv]
// rwcf_pkg: shared types, constants and helpers for the RIFF/WebP chunk filter.
// No dependencies; used by every module of the block.
`default_nettype none

package rwcf_pkg;

   // Result classes as seen on rsp_byte_class
   localparam logic [2:0] CLASS_HEAD    = 3'd0;
   localparam logic [2:0] CLASS_KEPT    = 3'd1;
   localparam logic [2:0] CLASS_DROP    = 3'd2;
   localparam logic [2:0] CLASS_TAIL    = 3'd3;
   localparam logic [2:0] CLASS_SUMMARY = 3'd4;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Fourcc codes, first file byte in bits 31:24
   localparam logic [31:0] FOURCC_RIFF = 32'h52494646;
   localparam logic [31:0] FOURCC_WEBP = 32'h57454250;

   localparam int unsigned WHITELIST_SIZE = 9;
   localparam logic [31:0] WHITELIST [WHITELIST_SIZE] = '{
      32'h56503858,  // VP8X
      32'h56503820,  // VP8 (space)
      32'h5650384C,  // VP8L
      32'h414C5048,  // ALPH
      32'h414E494D,  // ANIM
      32'h414E4D46,  // ANMF
      32'h49434350,  // ICCP
      32'h45584946,  // EXIF
      32'h584D5020   // XMP (space)
   };

   // One queue entry: an optional single byte, then a group of buffered
   // header bytes, then an optional summary.
   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  byte_value;
      logic [2:0]  byte_class;
      logic [3:0]  grp_count;
      logic [2:0]  grp_class;
      logic [63:0] grp_bytes;    // byte i in bits 8*i+7:8*i
      logic        sum_valid;
      logic        is_webp;
      logic        dropped_any;
      logic [30:0] body_length;
   } cmd_type;

   function automatic logic on_whitelist(input logic [31:0] fourcc);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < WHITELIST_SIZE; i++) begin
         if (fourcc == WHITELIST[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [7:0] magic_byte(input logic [31:0] word, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = word[31:24];
         2'd1: b = word[23:16];
         2'd2: b = word[15:8];
         default: b = word[7:0];
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[src/riff_webp_chunk_filter.sv]
// riff_webp_chunk_filter: top level, a classifier front, an entry queue and a result back end.
// Depends on rwcf_pkg, rwcf_front, rwcf_queue and rwcf_back.
//
// Usage:
//  - csr_*: write total_length (payload byte count) while the block is idle;
//    csr_ready is always high, a write lands on the edge where csr_valid is high.
//  - req_*: one payload byte per item, taken when req_push is high and
//    req_full low. A byte can be taken every cycle.
//  - rsp_*: result items leave through a queue-style port; the head item sits
//    on the ports while rsp_empty is low and goes on an edge with rsp_pop high.
//  - Each byte gives zero, one or eight items: chunk header bytes are held back
//    until the eighth arrives and then leave as a burst of eight. The final
//    byte of the payload adds any held-back header bytes as tail and a summary
//    item with rsp_last set; the next byte starts a new payload.
//  - Path: an item passes the queue, the working entry in rwcf_back and the
//    output register on its way to the result ports.
//  - Throughput: with rsp_pop high, one byte taken and one item delivered per
//    cycle; the back end emits one item a cycle and the queue (QUEUE_DEPTH
//    entries) absorbs the header bursts. req_full rises only when that queue is full.
//  - Stall: with rsp_pop low the output register holds its item; the back end
//    and then the queue fill, and the input side stalls through req_full.
//  - Reset (synchronous, active high) empties queue and output, sets
//    total_length to 1 and restarts the parse at the file header.
`default_nettype none

module riff_webp_chunk_filter #(
   parameter int unsigned QUEUE_DEPTH = rwcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [30:0] csr_total_length,
   // byte input
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   // results
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_byte_value,
   output logic [2:0]       rsp_byte_class,
   output logic             rsp_is_summary,
   output logic             rsp_is_webp,
   output logic             rsp_dropped_any,
   output logic [30:0]      rsp_body_length,
   output logic [31:0]      rsp_riff_size,
   output logic             rsp_keep_original,
   output logic             rsp_last
);

   rwcf_pkg::cmd_type front_cmd;
   rwcf_pkg::cmd_type head_cmd;
   logic              front_cmd_valid;
   logic              q_full, q_empty, q_pop;
   logic              take;

   // configuration register is always writable
   assign csr_ready = 1'b1;

   // a byte is taken whenever the queue has room; bytes that only fill the
   // header buffer push nothing
   assign req_full = q_full;
   assign take     = req_push && !q_full;

   rwcf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_total_length (csr_total_length),
      .take             (take),
      .data_byte        (req_data_byte),
      .cmd              (front_cmd),
      .cmd_valid        (front_cmd_valid)
   );

   rwcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take && front_cmd_valid),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_cmd),
      .empty     (q_empty)
   );

   rwcf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (head_cmd),
      .cmd_empty         (q_empty),
      .cmd_pop           (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_byte_class    (rsp_byte_class),
      .rsp_is_summary    (rsp_is_summary),
      .rsp_is_webp       (rsp_is_webp),
      .rsp_dropped_any   (rsp_dropped_any),
      .rsp_body_length   (rsp_body_length),
      .rsp_riff_size     (rsp_riff_size),
      .rsp_keep_original (rsp_keep_original),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[src/rwcf_front.sv]
// rwcf_front: takes payload bytes, tracks the RIFF/chunk walk and builds queue entries.
// Depends on rwcf_pkg; holds the total_length register.
`default_nettype none

module rwcf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [30:0]       csr_total_length,
   input  wire logic              take,
   input  wire logic [7:0]        data_byte,
   output rwcf_pkg::cmd_type      cmd,
   output logic                   cmd_valid
);

   typedef enum logic [3:0] {
      PH_FILE = 4'b0001,
      PH_HDR  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_TAIL = 4'b1000
   } phase_type;

   logic [30:0] total_ff;
   logic [30:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  store_ff [8];
   logic [7:0]  store_in [8];
   logic [2:0]  fill_ff, fill_in;
   logic [32:0] left_ff, left_in;
   logic        keep_chunk_ff, keep_chunk_in;
   logic        magic_ff, magic_in;
   logic        drop_ff, drop_in;
   logic [30:0] kept_ff, kept_in;

   logic [31:0] p_next;
   logic        final_byte;
   logic [31:0] size;
   logic [32:0] padded;
   logic        webp;

   always_comb begin
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      store_in      = store_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      keep_chunk_in = keep_chunk_ff;
      magic_in      = magic_ff;
      drop_in       = drop_ff;
      kept_in       = kept_ff;
      cmd           = '0;
      size          = '0;
      padded        = '0;
      webp          = 1'b0;

      p_next     = {1'b0, pos_ff} + 32'd1;
      final_byte = p_next >= {1'b0, total_ff};

      case (phase_ff)
         PH_FILE: begin
            if (pos_ff < 31'd4 &&
                data_byte != rwcf_pkg::magic_byte(rwcf_pkg::FOURCC_RIFF, pos_ff[1:0]))
               magic_in = 1'b0;
            if (pos_ff >= 31'd8 && pos_ff < 31'd12 &&
                data_byte != rwcf_pkg::magic_byte(rwcf_pkg::FOURCC_WEBP, pos_ff[1:0]))
               magic_in = 1'b0;
            cmd.byte_valid = 1'b1;
            cmd.byte_class = rwcf_pkg::CLASS_HEAD;
            if (pos_ff == 31'd11) begin
               phase_in = magic_in ? PH_HDR : PH_TAIL;
               fill_in  = 3'd0;
            end
         end
         PH_HDR: begin
            if (fill_ff == 3'd0 && ({1'b0, pos_ff} + 32'd8) > {1'b0, total_ff}) begin
               // fewer than eight bytes left: no room for a header
               phase_in       = PH_TAIL;
               cmd.byte_valid = 1'b1;
               cmd.byte_class = rwcf_pkg::CLASS_TAIL;
            end else begin
               store_in[fill_ff] = data_byte;
               if (fill_ff == 3'd7) begin
                  size    = {data_byte, store_ff[6], store_ff[5], store_ff[4]};
                  padded  = {1'b0, size} + {32'd0, size[0]};
                  fill_in = 3'd0;
                  cmd.grp_count = 4'd8;
                  if (({2'b0, p_next} + {1'b0, padded}) > {3'b0, total_ff}) begin
                     // chunk runs past the end
                     phase_in      = PH_TAIL;
                     cmd.grp_class = rwcf_pkg::CLASS_TAIL;
                  end else begin
                     keep_chunk_in = rwcf_pkg::on_whitelist(
                        {store_ff[0], store_ff[1], store_ff[2], store_ff[3]});
                     if (keep_chunk_in) begin
                        kept_in       = kept_ff + 31'd8 + padded[30:0];
                        cmd.grp_class = rwcf_pkg::CLASS_KEPT;
                     end else begin
                        drop_in       = 1'b1;
                        cmd.grp_class = rwcf_pkg::CLASS_DROP;
                     end
                     left_in  = padded;
                     phase_in = (padded != 33'd0) ? PH_BODY : PH_HDR;
                  end
               end else begin
                  fill_in = fill_ff + 3'd1;
               end
            end
         end
         PH_BODY: begin
            cmd.byte_valid = 1'b1;
            cmd.byte_class = keep_chunk_ff ? rwcf_pkg::CLASS_KEPT : rwcf_pkg::CLASS_DROP;
            left_in = left_ff - 33'd1;
            if (left_ff == 33'd1) phase_in = PH_HDR;
         end
         PH_TAIL: begin
            cmd.byte_valid = 1'b1;
            cmd.byte_class = rwcf_pkg::CLASS_TAIL;
         end
         default: begin
            phase_in = PH_FILE;
         end
      endcase

      cmd.byte_value = data_byte;
      for (int i = 0; i < 8; i++) cmd.grp_bytes[8*i +: 8] = store_in[i];

      if (final_byte) begin
         webp = magic_in && pos_ff >= 31'd11;
         // partial header still buffered goes out as tail
         if (phase_in == PH_HDR && fill_in != 3'd0) begin
            cmd.grp_count = {1'b0, fill_in};
            cmd.grp_class = rwcf_pkg::CLASS_TAIL;
         end
         cmd.sum_valid   = 1'b1;
         cmd.is_webp     = webp;
         cmd.dropped_any = webp && drop_in;
         cmd.body_length = webp ? kept_in : 31'd0;
         pos_in        = '0;
         phase_in      = PH_FILE;
         fill_in       = '0;
         left_in       = '0;
         keep_chunk_in = 1'b0;
         magic_in      = 1'b1;
         drop_in       = 1'b0;
         kept_in       = '0;
      end else begin
         pos_in = p_next[30:0];
      end

      cmd_valid = cmd.byte_valid || (cmd.grp_count != 4'd0) || cmd.sum_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= 31'd1;
         pos_ff        <= '0;
         phase_ff      <= PH_FILE;
         fill_ff       <= '0;
         left_ff       <= '0;
         keep_chunk_ff <= 1'b0;
         magic_ff      <= 1'b1;
         drop_ff       <= 1'b0;
         kept_ff       <= '0;
      end else begin
         if (csr_valid) total_ff <= csr_total_length;
         if (take) begin
            pos_ff        <= pos_in;
            phase_ff      <= phase_in;
            fill_ff       <= fill_in;
            left_ff       <= left_in;
            keep_chunk_ff <= keep_chunk_in;
            magic_ff      <= magic_in;
            drop_ff       <= drop_in;
            kept_ff       <= kept_in;
         end
      end
   end

   // header bytes: payload only, no reset
   always_ff @(posedge clock) begin
      if (take) store_ff <= store_in;
   end

endmodule

`default_nettype wire

[src/rwcf_queue.sv]
// rwcf_queue: short entry queue between classifier and result sequencer.
// Depends on rwcf_pkg for the entry type.
`default_nettype none

module rwcf_queue #(
   parameter int unsigned DEPTH = rwcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rwcf_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output rwcf_pkg::cmd_type      pop_data,
   output logic                   empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rwcf_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

[src/rwcf_back.sv]
// rwcf_back: expands queue entries into result items, one per cycle unless rsp_pop stalls;
// each goes into the output register. Depends on rwcf_pkg for the entry type and class codes.
`default_nettype none

module rwcf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rwcf_pkg::cmd_type cmd,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [7:0]             rsp_byte_value,
   output logic [2:0]             rsp_byte_class,
   output logic                   rsp_is_summary,
   output logic                   rsp_is_webp,
   output logic                   rsp_dropped_any,
   output logic [30:0]            rsp_body_length,
   output logic [31:0]            rsp_riff_size,
   output logic                   rsp_keep_original,
   output logic                   rsp_last
);

   // working entry
   logic        byte_pend_ff, byte_pend_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  bclass_ff, bclass_in;
   logic [3:0]  grp_left_ff, grp_left_in;
   logic [2:0]  grp_idx_ff, grp_idx_in;
   logic [2:0]  gclass_ff, gclass_in;
   logic [63:0] gbytes_ff, gbytes_in;
   logic        sum_pend_ff, sum_pend_in;
   logic        webp_ff, webp_in;
   logic        drop_ff, drop_in;
   logic [30:0] body_ff, body_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_value_ff, out_value_in;
   logic [2:0]  out_class_ff, out_class_in;
   logic        out_sum_ff, out_sum_in;
   logic        out_webp_ff, out_webp_in;
   logic        out_drop_ff, out_drop_in;
   logic [30:0] out_body_ff, out_body_in;
   logic [31:0] out_riff_ff, out_riff_in;
   logic        out_keep_ff, out_keep_in;

   logic out_adv, busy, emit, last_item;

   always_comb begin
      byte_pend_in = byte_pend_ff;
      byte_in      = byte_ff;
      bclass_in    = bclass_ff;
      grp_left_in  = grp_left_ff;
      grp_idx_in   = grp_idx_ff;
      gclass_in    = gclass_ff;
      gbytes_in    = gbytes_ff;
      sum_pend_in  = sum_pend_ff;
      webp_in      = webp_ff;
      drop_in      = drop_ff;
      body_in      = body_ff;

      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_class_in = out_class_ff;
      out_sum_in   = out_sum_ff;
      out_webp_in  = out_webp_ff;
      out_drop_in  = out_drop_ff;
      out_body_in  = out_body_ff;
      out_riff_in  = out_riff_ff;
      out_keep_in  = out_keep_ff;

      out_adv   = !out_valid_ff || rsp_pop;
      busy      = byte_pend_ff || (grp_left_ff != 4'd0) || sum_pend_ff;
      emit      = out_adv && busy;
      last_item = 1'b0;

      if (emit) begin
         out_valid_in = 1'b1;
         out_sum_in   = 1'b0;
         out_webp_in  = 1'b0;
         out_drop_in  = 1'b0;
         out_body_in  = '0;
         out_riff_in  = '0;
         out_keep_in  = 1'b0;
         if (byte_pend_ff) begin
            out_value_in = byte_ff;
            out_class_in = bclass_ff;
            byte_pend_in = 1'b0;
            last_item    = (grp_left_ff == 4'd0) && !sum_pend_ff;
         end else if (grp_left_ff != 4'd0) begin
            out_value_in = gbytes_ff[{grp_idx_ff, 3'b000} +: 8];
            out_class_in = gclass_ff;
            grp_left_in  = grp_left_ff - 4'd1;
            grp_idx_in   = grp_idx_ff + 3'd1;
            last_item    = (grp_left_ff == 4'd1) && !sum_pend_ff;
         end else begin
            out_value_in = '0;
            out_class_in = rwcf_pkg::CLASS_SUMMARY;
            out_sum_in   = 1'b1;
            out_webp_in  = webp_ff;
            out_drop_in  = drop_ff;
            out_body_in  = body_ff;
            out_riff_in  = {1'b0, body_ff} + 32'd4;
            out_keep_in  = !webp_ff || !drop_ff || (body_ff == 31'd0);
            sum_pend_in  = 1'b0;
            last_item    = 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      cmd_pop = !cmd_empty && (!busy || (emit && last_item));
      if (cmd_pop) begin
         byte_pend_in = cmd.byte_valid;
         byte_in      = cmd.byte_value;
         bclass_in    = cmd.byte_class;
         grp_left_in  = cmd.grp_count;
         grp_idx_in   = 3'd0;
         gclass_in    = cmd.grp_class;
         gbytes_in    = cmd.grp_bytes;
         sum_pend_in  = cmd.sum_valid;
         webp_in      = cmd.is_webp;
         drop_in      = cmd.dropped_any;
         body_in      = cmd.body_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pend_ff <= 1'b0;
         grp_left_ff  <= '0;
         sum_pend_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         byte_pend_ff <= byte_pend_in;
         grp_left_ff  <= grp_left_in;
         sum_pend_ff  <= sum_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      bclass_ff    <= bclass_in;
      grp_idx_ff   <= grp_idx_in;
      gclass_ff    <= gclass_in;
      gbytes_ff    <= gbytes_in;
      webp_ff      <= webp_in;
      drop_ff      <= drop_in;
      body_ff      <= body_in;
      out_value_ff <= out_value_in;
      out_class_ff <= out_class_in;
      out_sum_ff   <= out_sum_in;
      out_webp_ff  <= out_webp_in;
      out_drop_ff  <= out_drop_in;
      out_body_ff  <= out_body_in;
      out_riff_ff  <= out_riff_in;
      out_keep_ff  <= out_keep_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_byte_value    = out_value_ff;
   assign rsp_byte_class    = out_class_ff;
   assign rsp_is_summary    = out_sum_ff;
   assign rsp_is_webp       = out_webp_ff;
   assign rsp_dropped_any   = out_drop_ff;
   assign rsp_body_length   = out_body_ff;
   assign rsp_riff_size     = out_riff_ff;
   assign rsp_keep_original = out_keep_ff;
   assign rsp_last          = out_sum_ff;

endmodule

`default_nettype wire

[src/rwcf_checker.sv]
// rwcf_checker: port-level assertions for riff_webp_chunk_filter, bound to the top level.
// Depends on rwcf_pkg for class codes.
`default_nettype none

module rwcf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [7:0]  rsp_byte_value,
   input wire logic [2:0]  rsp_byte_class,
   input wire logic        rsp_is_summary,
   input wire logic        rsp_is_webp,
   input wire logic        rsp_dropped_any,
   input wire logic [30:0] rsp_body_length,
   input wire logic [31:0] rsp_riff_size,
   input wire logic        rsp_keep_original,
   input wire logic        rsp_last
);

   // after reset nothing is waiting and input is open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or queue not clear after reset");

   // a summary carries its class and closes the payload
   a_summary_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_summary) |->
         (rsp_byte_class == rwcf_pkg::CLASS_SUMMARY) && rsp_last && (rsp_byte_value == 8'd0))
      else $error("summary item malformed");

   // new RIFF size follows the kept body length
   a_riff_size: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_summary) |-> (rsp_riff_size == ({1'b0, rsp_body_length} + 32'd4)))
      else $error("riff size does not match body length");

   // non-WebP payload keeps the original and reports nothing dropped
   a_not_webp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_summary && !rsp_is_webp) |->
         rsp_keep_original && !rsp_dropped_any && (rsp_body_length == 31'd0))
      else $error("summary of non-WebP payload inconsistent");

   // a stalled result item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         !rsp_empty && $stable(rsp_byte_value) && $stable(rsp_byte_class) && $stable(rsp_last))
      else $error("stalled result item changed");

endmodule

bind riff_webp_chunk_filter rwcf_checker u_checker (.*);

`default_nettype wire

[tb/rwcf_scoreboard_pkg.sv]
// rwcf_scoreboard_pkg: item type and scoreboard for the RIFF/WebP chunk filter bench.
// Depends on rwcf_pkg for result classes, magic words and the fourcc whitelist.
`timescale 1ns / 100ps

package rwcf_scoreboard_pkg;

   // One result item, field for field as on the rsp_ ports
   typedef struct packed {
      logic [7:0]  byte_value;
      logic [2:0]  byte_class;
      logic        is_summary;
      logic        is_webp;
      logic        dropped_any;
      logic [30:0] body_length;
      logic [31:0] riff_size;
      logic        keep_original;
      logic        last;
   } filter_item_type;

   typedef enum logic [3:0] {
      SCAN_MAGIC  = 4'b0001,
      SCAN_HEADER = 4'b0010,
      SCAN_BODY   = 4'b0100,
      SCAN_TAIL   = 4'b1000
   } scan_phase_type;

   class chunk_scoreboard;
      logic [30:0]     length_reg;
      logic [31:0]     pos;
      scan_phase_type  phase;
      logic [7:0]      hdr_buf [8];
      int unsigned     hdr_count;
      longint unsigned body_left;
      bit              in_kept_chunk;
      bit              magic_good;
      bit              saw_drop;
      logic [31:0]     kept_bytes;
      filter_item_type expected_items [$];
      int unsigned     mismatches;

      function new();
         length_reg = 31'd1;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         pos = 0;
         phase = SCAN_MAGIC;
         foreach (hdr_buf[i]) hdr_buf[i] = 8'h00;
         hdr_count = 0;
         body_left = 0;
         in_kept_chunk = 0;
         magic_good = 1;
         saw_drop = 0;
         kept_bytes = 0;
      endfunction

      function void set_length(logic [30:0] value);
         length_reg = value;
      endfunction

      function void queue_item(logic [7:0] value, logic [2:0] cls);
         filter_item_type it;
         it = '0;
         it.byte_value = value;
         it.byte_class = cls;
         expected_items.push_back(it);
      endfunction

      function bit whitelisted(logic [31:0] fourcc);
         for (int i = 0; i < rwcf_pkg::WHITELIST_SIZE; i++)
            if (fourcc == rwcf_pkg::WHITELIST[i]) return 1;
         return 0;
      endfunction

      // One accepted payload byte: work out every item it releases
      function void take_byte(logic [7:0] b);
         longint unsigned p, limit, chunk_size, padded;
         logic [31:0]     riff_word, webp_word, body;
         logic [2:0]      cls;
         bit              webp, dropped;
         filter_item_type sum;
         p = pos;
         limit = length_reg;
         riff_word = rwcf_pkg::FOURCC_RIFF;
         webp_word = rwcf_pkg::FOURCC_WEBP;
         case (phase)
            SCAN_MAGIC: begin
               if (p < 4 && b != riff_word[8 * (3 - int'(p)) +: 8]) magic_good = 0;
               if (p >= 8 && p < 12 && b != webp_word[8 * (11 - int'(p)) +: 8]) magic_good = 0;
               queue_item(b, rwcf_pkg::CLASS_HEAD);
               if (p == 11) begin
                  phase = magic_good ? SCAN_HEADER : SCAN_TAIL;
                  hdr_count = 0;
               end
            end
            SCAN_HEADER: begin
               if (hdr_count == 0 && p + 8 > limit) begin
                  // too few bytes left for a chunk header
                  phase = SCAN_TAIL;
                  queue_item(b, rwcf_pkg::CLASS_TAIL);
               end else begin
                  hdr_buf[hdr_count] = b;
                  hdr_count++;
                  if (hdr_count == 8) begin
                     chunk_size = {32'd0, hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
                     padded = chunk_size + (chunk_size & 1);
                     hdr_count = 0;
                     if (p + 1 + padded > limit) begin
                        phase = SCAN_TAIL;
                        cls = rwcf_pkg::CLASS_TAIL;
                     end else begin
                        in_kept_chunk = whitelisted({hdr_buf[0], hdr_buf[1],
                                                     hdr_buf[2], hdr_buf[3]});
                        if (in_kept_chunk) begin
                           kept_bytes = 32'((longint'(kept_bytes) + 8 + padded)
                                            & 64'h7FFF_FFFF);
                           cls = rwcf_pkg::CLASS_KEPT;
                        end else begin
                           saw_drop = 1;
                           cls = rwcf_pkg::CLASS_DROP;
                        end
                        body_left = padded;
                        phase = (padded != 0) ? SCAN_BODY : SCAN_HEADER;
                     end
                     for (int i = 0; i < 8; i++) queue_item(hdr_buf[i], cls);
                  end
               end
            end
            SCAN_BODY: begin
               queue_item(b, in_kept_chunk ? rwcf_pkg::CLASS_KEPT : rwcf_pkg::CLASS_DROP);
               if (body_left > 0) body_left--;
               if (body_left == 0) phase = SCAN_HEADER;
            end
            default: queue_item(b, rwcf_pkg::CLASS_TAIL);
         endcase

         if (p + 1 >= limit) begin
            webp = magic_good && p >= 11;
            body = webp ? kept_bytes : 32'd0;
            dropped = webp && saw_drop;
            // a half-buffered chunk header leaves as tail ahead of the summary
            if (phase == SCAN_HEADER)
               for (int i = 0; i < hdr_count; i++) queue_item(hdr_buf[i], rwcf_pkg::CLASS_TAIL);
            sum = '0;
            sum.byte_class = rwcf_pkg::CLASS_SUMMARY;
            sum.is_summary = 1'b1;
            sum.is_webp = webp;
            sum.dropped_any = dropped;
            sum.body_length = body[30:0];
            sum.riff_size = body + 32'd4;
            sum.keep_original = !webp || !dropped || body == 0;
            sum.last = 1'b1;
            expected_items.push_back(sum);
            restart();
         end else begin
            pos = 32'(p + 1);
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_item(filter_item_type got);
         filter_item_type want;
         if (expected_items.size() == 0) begin
            $display("%0t ns: unexpected item, expected none, got value %0h class %0d",
                     $time, got.byte_value, got.byte_class);
            mismatches++;
            return;
         end
         want = expected_items.pop_front();
         compare_field("byte_value", want.byte_value, got.byte_value);
         compare_field("byte_class", want.byte_class, got.byte_class);
         compare_field("is_summary", want.is_summary, got.is_summary);
         compare_field("is_webp", want.is_webp, got.is_webp);
         compare_field("dropped_any", want.dropped_any, got.dropped_any);
         compare_field("body_length", want.body_length, got.body_length);
         compare_field("riff_size", want.riff_size, got.riff_size);
         compare_field("keep_original", want.keep_original, got.keep_original);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

[tb/testbench.sv]
// testbench: self-checking bench for riff_webp_chunk_filter.
// Depends on rwcf_pkg and rwcf_scoreboard_pkg; drives byte items and pops results
// with random gaps on both sides, checking each item against the scoreboard.
`timescale 1ns / 100ps

module testbench;

   typedef logic [7:0] byte_stream_type [$];

   localparam logic [30:0] MAX_LENGTH     = 31'h7FFF_FFFF;
   localparam int          SETTLE_CYCLES  = 6;    // margin after the last expected item
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          RANDOM_ITEMS   = 140;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [30:0] csr_total_length;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_byte_value;
   logic [2:0]  rsp_byte_class;
   logic        rsp_is_summary;
   logic        rsp_is_webp;
   logic        rsp_dropped_any;
   logic [30:0] rsp_body_length;
   logic [31:0] rsp_riff_size;
   logic        rsp_keep_original;
   logic        rsp_last;

   rwcf_scoreboard_pkg::chunk_scoreboard board = new();
   bit              gaps_on = 1'b1;   // cleared for a stretch of back-to-back traffic
   int unsigned     quiet_cycles = 0;

   riff_webp_chunk_filter uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_total_length  (csr_total_length),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_byte_class    (rsp_byte_class),
      .rsp_is_summary    (rsp_is_summary),
      .rsp_is_webp       (rsp_is_webp),
      .rsp_dropped_any   (rsp_dropped_any),
      .rsp_body_length   (rsp_body_length),
      .rsp_riff_size     (rsp_riff_size),
      .rsp_keep_original (rsp_keep_original),
      .rsp_last          (rsp_last)
   );

   always #4 clock = ~clock;

   // Watchdog: any handshake restarts the count; a hung block ends the run.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: pop decided at the falling edge, item taken at the rising edge.
   initial begin
      rwcf_scoreboard_pkg::filter_item_type seen;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop = !(gaps_on && $urandom_range(99) < 20);
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            seen.byte_value    = rsp_byte_value;
            seen.byte_class    = rsp_byte_class;
            seen.is_summary    = rsp_is_summary;
            seen.is_webp       = rsp_is_webp;
            seen.dropped_any   = rsp_dropped_any;
            seen.body_length   = rsp_body_length;
            seen.riff_size     = rsp_riff_size;
            seen.keep_original = rsp_keep_original;
            seen.last          = rsp_last;
            board.check_item(seen);
         end
      end
   end

   // One byte item; push stays high across back-to-back items.
   task automatic push_byte(input logic [7:0] b);
      bit taken;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         if (gaps_on && $urandom_range(99) < 20) begin
            req_push = 1'b0;
         end else begin
            req_push = 1'b1;
            req_data_byte = b;
         end
         @(posedge clock);
         if (req_push && !req_full) begin
            board.take_byte(b);
            taken = 1;
         end
      end
   endtask

   // Wait for every expected item, then wait out SETTLE_CYCLES so that an unexpected item would show.
   task automatic settle();
      @(negedge clock);
      req_push = 1'b0;
      while (board.expected_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [30:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_total_length = value;
      do @(posedge clock); while (!csr_ready);
      board.set_length(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_file(input byte_stream_type data);
      foreach (data[i]) push_byte(data[i]);
   endtask

   task automatic run_payload(input byte_stream_type data, input logic [30:0] length);
      settle();
      write_length(length);
      send_file(data);
   endtask

   // fourcc / magic words go out first byte first
   function automatic void add_word(ref byte_stream_type data, input logic [31:0] w);
      for (int i = 3; i >= 0; i--) data.push_back(w[8 * i +: 8]);
   endfunction

   // A WebP-shaped file: valid magic, a few chunks, sometimes trailing junk.
   function automatic byte_stream_type random_file();
      byte_stream_type data;
      logic [31:0]     fourcc, chunk_size;
      int unsigned     fill;
      data = {};
      add_word(data, rwcf_pkg::FOURCC_RIFF);
      add_word(data, $urandom());
      add_word(data, rwcf_pkg::FOURCC_WEBP);
      repeat ($urandom_range(0, 3)) begin
         fourcc = ($urandom_range(99) < 60)
                  ? rwcf_pkg::WHITELIST[$urandom_range(rwcf_pkg::WHITELIST_SIZE - 1)]
                  : 32'($urandom());
         case ($urandom_range(19))
            0:       chunk_size = 32'hFFFF_FFF0 | 32'($urandom_range(15));  // near 2^32
            1:       chunk_size = $urandom();
            default: chunk_size = $urandom_range(0, 7);
         endcase
         add_word(data, fourcc);
         for (int i = 0; i < 4; i++) data.push_back(chunk_size[8 * i +: 8]);
         // oversized chunks get a few bytes only, so they end up truncated
         fill = (chunk_size > 16) ? $urandom_range(0, 4) : chunk_size + chunk_size[0];
         repeat (fill) data.push_back(8'($urandom()));
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 7)) data.push_back(8'($urandom()));
      return data;
   endfunction

   initial begin
      byte_stream_type data;
      int unsigned     sent, k, pick, tail_count;
      int              delta;
      logic [30:0]     new_length;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_total_length = '0;
      req_push = 1'b0;
      req_data_byte = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // length straight out of reset: a single byte is the whole payload
      push_byte(8'hFF);
      // length zero acts like one
      run_payload({8'h00}, 31'd0);
      // short payload, all file header bytes
      run_payload({8'h52, 8'h49, 8'h46}, 31'd3);
      // valid file: odd-sized kept chunk with padding, then a short tail
      data = {};
      add_word(data, rwcf_pkg::FOURCC_RIFF);
      add_word(data, 32'hFFFF_FFFF);
      add_word(data, rwcf_pkg::FOURCC_WEBP);
      add_word(data, rwcf_pkg::WHITELIST[7]);
      add_word(data, 32'h0100_0000);
      data.push_back(8'h00);
      data.push_back(8'hFF);
      data.push_back(8'hA5);
      data.push_back(8'h5A);
      data.push_back(8'h0F);
      run_payload(data, 31'(data.size()));

      // --- random payloads ---
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         gaps_on = !(sent >= 40 && sent < 100);
         data = random_file();
         pick = $urandom_range(9);
         if (pick == 0) begin
            // one magic byte spoilt
            k = $urandom_range(7);
            k = (k < 4) ? k : k + 4;
            data[k] = data[k] ^ (8'd1 << $urandom_range(7));
            run_payload(data, 31'(data.size()));
            sent += data.size();
         end else if (pick == 1) begin
            // fewer than twelve bytes
            data = data[0 : $urandom_range(0, 10)];
            run_payload(data, 31'(data.size()));
            sent += data.size();
         end else if (pick == 2) begin
            // cut short somewhere past the file header
            data = data[0 : $urandom_range(11, data.size() - 1)];
            run_payload(data, 31'(data.size()));
            sent += data.size();
         end else if (pick <= 4) begin
            // open-ended length, then the real one written part way through
            k = $urandom_range(1, data.size() - 1);
            settle();
            write_length(MAX_LENGTH);
            send_file(data[0 : k - 1]);
            settle();
            delta = $urandom_range(1) ? int'($urandom_range(0, 4)) - 2
                                      : int'($urandom_range(0, data.size() - k));
            new_length = (int'(k) + delta < 0) ? 31'd0 : 31'(int'(k) + delta);
            write_length(new_length);
            tail_count = (delta < 1) ? 1 : delta;
            send_file(data[k : k + tail_count - 1]);
            sent += k + tail_count;
         end else begin
            run_payload(data, 31'(data.size()));
            sent += data.size();
         end
      end

      settle();
      if (board.mismatches == 0 && board.expected_items.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[riff_webp_chunk_filter.f]
src/rwcf_pkg.sv
src/rwcf_front.sv
src/rwcf_queue.sv
src/rwcf_back.sv
src/riff_webp_chunk_filter.sv
src/rwcf_checker.sv
tb/rwcf_scoreboard_pkg.sv
tb/testbench.sv
